[design/pfx_pkg.sv]
// Package for the postfix expression evaluator: sizes, character codes,
// status and operation codes, state encoding and the request/result structs.
// No dependencies.
package pfx_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int FRAC_BITS   = 16;

    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int INT_W     = DATA_W - FRAC_BITS;
    localparam int EXP_W     = 5;
    localparam int DIV_W     = DATA_W + FRAC_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);
    localparam int CNT_W     = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W     = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    localparam logic [DATA_W-1:0] FX_ONE   = DATA_W'(1) << FRAC_BITS;
    localparam logic [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    localparam logic [7:0] SYM_ZERO = 8'h30;
    localparam logic [7:0] SYM_NINE = 8'h39;
    localparam logic [7:0] SYM_ADD  = 8'h2B;
    localparam logic [7:0] SYM_SUB  = 8'h2D;
    localparam logic [7:0] SYM_MUL  = 8'h2A;
    localparam logic [7:0] SYM_DIV  = 8'h2F;
    localparam logic [7:0] SYM_POW  = 8'h5E;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_UNDER  = 3'd1,
        ST_FULL   = 3'd2,
        ST_DIV0   = 3'd3,
        ST_BADEXP = 3'd4,
        ST_SAT    = 3'd5
    } pfx_status_t;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_POW
    } pfx_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LDB,
        S_EXEC,
        S_MUL,
        S_CLAMP,
        S_DIV,
        S_DFIX,
        S_PUSH,
        S_TOP,
        S_OUT
    } pfx_state_t;

    typedef struct packed {
        logic [7:0] symbol;
        logic       is_last;
    } pfx_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        pfx_status_t              status;
    } pfx_out_t;

    typedef struct packed {
        logic              sat;
        logic [DATA_W-1:0] val;
    } pfx_sat_t;

    // Clamp a sum that carries one guard bit.
    function automatic pfx_sat_t clamp_sum(input logic [DATA_W:0] s);
        pfx_sat_t r;
        r.sat = (s[DATA_W] != s[DATA_W-1]);
        r.val = r.sat ? (s[DATA_W] ? DATA_MIN : DATA_MAX) : s[DATA_W-1:0];
        return r;
    endfunction

    // Floor-shift a full product by FRAC_BITS, then clamp.
    function automatic pfx_sat_t clamp_prod(input logic [PROD_W-1:0] p);
        logic [PROD_W-1:0] sh;
        pfx_sat_t          r;
        sh    = PROD_W'($signed(p) >>> FRAC_BITS);
        r.sat = !((&sh[PROD_W-1:DATA_W-1]) || !(|sh[PROD_W-1:DATA_W-1]));
        r.val = r.sat ? (sh[PROD_W-1] ? DATA_MIN : DATA_MAX) : sh[DATA_W-1:0];
        return r;
    endfunction

endpackage

[design/postfix_expression_evaluator_unit.sv]
// Postfix expression evaluator: operand stack, sequencer, shared multiplier
// and bit-serial divider. Depends on pfx_pkg.
//
// Usage:
//  - Request channel (s_valid/s_ready/s_payload): one character per request.
//    Digits push d * 2^FRAC_BITS; + - * / ^ pop A (top) and B, push B op A;
//    other characters are ignored. is_last closes the expression.
//  - Result channel (m_valid/m_ready/m_payload): one result per expression,
//    issued after the request marked is_last: the top value (Q16.16) and a
//    status; value is zero for statuses underflow..bad exponent.
//  - States per request, from acceptance until s_ready returns:
//      ignored char or digit: S_IDLE only;  + and -: S_LDB, S_EXEC, S_PUSH;
//      ^ with exponent e: S_LDB, S_EXEC, e steps of the registered 32x32
//        multiplier (S_MUL) and its clamp (S_CLAMP), S_PUSH;  *: as ^ with e=1;
//      /: S_LDB, S_EXEC, S_DIV (the restoring divider retires one quotient bit
//        per cycle), S_DFIX, S_PUSH.
//    A last request adds a stack read (S_TOP), then the result register (S_OUT).
//  - The result register holds a finished result while the next expression
//    is already being accepted; only the next result waits for m_ready.
//  - Reset (aresetn low, synchronous) empties the stack, clears the sticky
//    error and drops m_valid. Stack contents are not cleared.
//  - The first error of an expression is sticky until its result is issued.
module postfix_expression_evaluator_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pfx_pkg::pfx_in_t  s_payload,
    output logic              m_valid,
    input  logic              m_ready,
    output pfx_pkg::pfx_out_t m_payload
);
    import pfx_pkg::*;

    // Control state
    pfx_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    pfx_status_t       err_reg, err_next;
    logic              m_valid_reg, m_valid_next;

    // Working registers
    logic              last_reg, last_next;
    pfx_op_t           op_reg, op_next;
    logic [DATA_W-1:0] a_reg, a_next;
    logic [DATA_W-1:0] res_reg, res_next;
    logic              sat_reg, sat_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [EXP_W-1:0]  iter_reg, iter_next;
    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] dvs_reg, dvs_next;
    logic [DIV_CNT_W-1:0] bit_reg, bit_next;
    logic              neg_reg, neg_next;
    pfx_out_t          m_payload_reg, m_payload_next;

    // Operand stack: one write port, one registered read port.
    // rd_data_reg holds B once an operator has loaded it.
    logic [DATA_W-1:0] stk_mem [STACK_DEPTH];
    logic [DATA_W-1:0] rd_data_reg;
    logic              wr_en, rd_en;
    logic [IDX_W-1:0]  wr_addr, rd_addr;
    logic [DATA_W-1:0] wr_data;

    // Decode of the incoming character
    logic              sym_digit, sym_op;
    pfx_op_t           sym_code;
    logic [7:0]        sym_off;
    logic [DATA_W-1:0] dig_val;

    // Datapath helpers
    logic [CNT_W-1:0]  cnt_m1, cnt_m2;
    logic [DATA_W:0]   addend, sum;
    pfx_sat_t          sum_clamp, prod_clamp;
    logic [INT_W-1:0]  pow_int;
    logic              exp_ok;
    logic [EXP_W-1:0]  exp_val;
    logic [DATA_W-1:0] mag_a, mag_b;
    logic [DATA_W:0]   rem_sh, rem_diff;
    logic              q_bit;
    logic [DIV_W-DATA_W:0] q_hi;
    logic              q_fit_pos, q_fit_neg;
    pfx_state_t        done_st;
    pfx_status_t       out_st;

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    assign cnt_m1 = cnt_reg - CNT_W'(1);
    assign cnt_m2 = cnt_reg - CNT_W'(2);

    always_comb begin
        sym_digit = (s_payload.symbol inside {[SYM_ZERO:SYM_NINE]});
        sym_op    = 1'b1;
        sym_code  = OP_ADD;
        case (s_payload.symbol)
            SYM_ADD: sym_code = OP_ADD;
            SYM_SUB: sym_code = OP_SUB;
            SYM_MUL: sym_code = OP_MUL;
            SYM_DIV: sym_code = OP_DIV;
            SYM_POW: sym_code = OP_POW;
            default: sym_op   = 1'b0;
        endcase
        sym_off = s_payload.symbol - SYM_ZERO;
        dig_val = {{(DATA_W-4){1'b0}}, sym_off[3:0]} << FRAC_BITS;
    end

    // Add/subtract share one adder; B sits in rd_data_reg, A in a_reg.
    assign addend    = (op_reg == OP_SUB) ? -{a_reg[DATA_W-1], a_reg}
                                          : {a_reg[DATA_W-1], a_reg};
    assign sum       = {rd_data_reg[DATA_W-1], rd_data_reg} + addend;
    assign sum_clamp = clamp_sum(sum);
    assign prod_clamp = clamp_prod(prod_reg);

    // Exponent: A truncated toward zero must land in 0..31.
    // A negative A above -1.0 truncates to zero and is legal.
    assign pow_int = a_reg[DATA_W-1:FRAC_BITS];
    assign exp_ok  = a_reg[DATA_W-1] ? ((&pow_int) && (|a_reg[FRAC_BITS-1:0]))
                                     : (pow_int[INT_W-1:EXP_W] == '0);
    assign exp_val = a_reg[DATA_W-1] ? '0 : pow_int[EXP_W-1:0];

    assign mag_a = a_reg[DATA_W-1] ? -a_reg : a_reg;
    assign mag_b = rd_data_reg[DATA_W-1] ? -rd_data_reg : rd_data_reg;

    // Restoring divider step
    assign rem_sh   = {rem_reg, quo_reg[DIV_W-1]};
    assign rem_diff = rem_sh - {1'b0, dvs_reg};
    assign q_bit    = !rem_diff[DATA_W];

    // Quotient range check: positive up to 2^31-1, negative down to -2^31
    assign q_hi      = quo_reg[DIV_W-1:DATA_W-1];
    assign q_fit_pos = (q_hi == '0);
    assign q_fit_neg = q_fit_pos
                    || ((q_hi == (DIV_W-DATA_W+1)'(1)) && (quo_reg[DATA_W-2:0] == '0));

    assign done_st = last_reg ? S_TOP : S_IDLE;

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        err_next       = err_reg;
        m_valid_next   = m_valid_reg;
        last_next      = last_reg;
        op_next        = op_reg;
        a_next         = a_reg;
        res_next       = res_reg;
        sat_next       = sat_reg;
        prod_next      = prod_reg;
        iter_next      = iter_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        dvs_next       = dvs_reg;
        bit_next       = bit_reg;
        neg_next       = neg_reg;
        m_payload_next = m_payload_reg;
        wr_en          = 1'b0;
        wr_addr        = cnt_reg[IDX_W-1:0];
        wr_data        = dig_val;
        rd_en          = 1'b0;
        rd_addr        = cnt_m1[IDX_W-1:0];
        out_st         = err_reg;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    last_next  = s_payload.is_last;
                    op_next    = sym_code;
                    state_next = s_payload.is_last ? S_TOP : S_IDLE;
                    if (err_reg == ST_OK) begin
                        if (sym_digit) begin
                            if (cnt_reg == CNT_W'(STACK_DEPTH)) begin
                                err_next = ST_FULL;
                            end else begin
                                wr_en    = 1'b1;
                                cnt_next = cnt_reg + CNT_W'(1);
                            end
                        end else if (sym_op) begin
                            if (cnt_reg < CNT_W'(2)) begin
                                err_next = ST_UNDER;
                            end else begin
                                rd_en      = 1'b1;   // fetch A
                                state_next = S_LDB;
                            end
                        end
                    end
                end
            end
            S_LDB: begin
                a_next     = rd_data_reg;
                rd_en      = 1'b1;                   // fetch B
                rd_addr    = cnt_m2[IDX_W-1:0];
                state_next = S_EXEC;
            end
            S_EXEC: begin
                case (op_reg)
                    OP_ADD, OP_SUB: begin
                        res_next   = sum_clamp.val;
                        sat_next   = sum_clamp.sat;
                        state_next = S_PUSH;
                    end
                    OP_MUL: begin
                        // one pass through the power loop: A * B
                        res_next   = a_reg;
                        iter_next  = EXP_W'(1);
                        sat_next   = 1'b0;
                        state_next = S_MUL;
                    end
                    OP_DIV: begin
                        if (a_reg == '0) begin
                            err_next   = ST_DIV0;
                            state_next = done_st;
                        end else begin
                            quo_next   = {mag_b, {FRAC_BITS{1'b0}}};
                            rem_next   = '0;
                            dvs_next   = mag_a;
                            bit_next   = DIV_CNT_W'(DIV_W);
                            neg_next   = a_reg[DATA_W-1] ^ rd_data_reg[DATA_W-1];
                            sat_next   = 1'b0;
                            state_next = S_DIV;
                        end
                    end
                    OP_POW: begin
                        if (!exp_ok) begin
                            err_next   = ST_BADEXP;
                            state_next = done_st;
                        end else begin
                            res_next   = FX_ONE;
                            iter_next  = exp_val;
                            sat_next   = 1'b0;
                            state_next = (exp_val == '0) ? S_PUSH : S_MUL;
                        end
                    end
                    default: state_next = done_st;
                endcase
            end
            S_MUL: begin
                prod_next  = $signed(res_reg) * $signed(rd_data_reg);
                state_next = S_CLAMP;
            end
            S_CLAMP: begin
                res_next   = prod_clamp.val;
                sat_next   = sat_reg | prod_clamp.sat;
                iter_next  = iter_reg - EXP_W'(1);
                state_next = (iter_reg == EXP_W'(1)) ? S_PUSH : S_MUL;
            end
            S_DIV: begin
                rem_next   = q_bit ? rem_diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
                quo_next   = {quo_reg[DIV_W-2:0], q_bit};
                bit_next   = bit_reg - DIV_CNT_W'(1);
                state_next = (bit_reg == DIV_CNT_W'(1)) ? S_DFIX : S_DIV;
            end
            S_DFIX: begin
                if (neg_reg) begin
                    sat_next = !q_fit_neg;
                    res_next = q_fit_neg ? -quo_reg[DATA_W-1:0] : DATA_MIN;
                end else begin
                    sat_next = !q_fit_pos;
                    res_next = q_fit_pos ? quo_reg[DATA_W-1:0] : DATA_MAX;
                end
                state_next = S_PUSH;
            end
            S_PUSH: begin
                // pop two, push one
                wr_en    = 1'b1;
                wr_addr  = cnt_m2[IDX_W-1:0];
                wr_data  = res_reg;
                cnt_next = cnt_m1;
                if (sat_reg) begin
                    err_next = ST_SAT;
                end
                state_next = done_st;
            end
            S_TOP: begin
                rd_en      = 1'b1;                   // fetch the top for the result
                state_next = S_OUT;
            end
            S_OUT: begin
                if ((err_reg == ST_OK || err_reg == ST_SAT) && cnt_reg == '0) begin
                    out_st = ST_UNDER;
                end
                if (!m_valid_reg || m_ready) begin
                    m_payload_next.status = out_st;
                    m_payload_next.value  = (out_st == ST_OK || out_st == ST_SAT)
                                          ? rd_data_reg : '0;
                    m_valid_next          = 1'b1;
                    cnt_next              = '0;
                    err_next              = ST_OK;
                    state_next            = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            err_reg     <= ST_OK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            err_reg     <= err_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        last_reg      <= last_next;
        op_reg        <= op_next;
        a_reg         <= a_next;
        res_reg       <= res_next;
        sat_reg       <= sat_next;
        prod_reg      <= prod_next;
        iter_reg      <= iter_next;
        quo_reg       <= quo_next;
        rem_reg       <= rem_next;
        dvs_reg       <= dvs_next;
        bit_reg       <= bit_next;
        neg_reg       <= neg_next;
        m_payload_reg <= m_payload_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            stk_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= stk_mem[rd_addr];
        end
    end

endmodule

[design/pfx_chk.sv]
// Port-level checks for the postfix expression evaluator, bound to its top.
// Depends on pfx_pkg and postfix_expression_evaluator_unit.
module pfx_chk (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input pfx_pkg::pfx_in_t  s_payload,
    input logic              m_valid,
    input logic              m_ready,
    input pfx_pkg::pfx_out_t m_payload
);
    import pfx_pkg::*;

    // result held while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("result dropped or changed while stalled");

    // error results carry a zero value
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_payload.status == ST_UNDER || m_payload.status == ST_FULL
                 || m_payload.status == ST_DIV0 || m_payload.status == ST_BADEXP)
        |-> m_payload.value == '0)
        else $error("error result with nonzero value");

    // closing an expression always needs a stack read before the next request
    a_last_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_payload.is_last |=> !s_ready)
        else $error("ready right after last request");

    // reset drops the result channel
    a_rst_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind postfix_expression_evaluator_unit pfx_chk u_pfx_chk (.*);
